// ===== sv/lsfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfd_pkg
// Shared constants, codes and controller/datapath handshake structs for the
// scan frame decoder.
// ----------------------------------------------------------------------------
package lsfd_pkg;

  // default geometry
  localparam int NUM_ANGLES_DEF         = 360;
  localparam int READINGS_PER_FRAME_DEF = 6;

  // frame layout
  localparam logic [7:0] SYNC_BYTE     = 8'hFA;
  localparam logic [7:0] INDEX_BASE    = 8'hA0;
  localparam logic [7:0] CHECK_BASE    = 8'hFF;
  localparam int         FIRST_READING = 4;
  localparam int         READING_BYTES = 6;
  localparam int         INDEX_POS     = 1;

  // field widths
  localparam int ANGLE_W = 9;
  localparam int VAL_W   = 16;

  // input opcodes
  localparam logic [1:0] OP_RECV  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // frame status codes
  localparam logic [1:0] ST_STORED     = 2'd0;
  localparam logic [1:0] ST_BAD_SUM    = 2'd1;
  localparam logic [1:0] ST_BAD_NUMBER = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DIST_LIMIT    = 2'd0;
  localparam logic [1:0] CFG_MIN_INTENSITY = 2'd1;
  localparam logic [1:0] CFG_INVERT        = 2'd2;

  // reading byte offsets inside one reading
  localparam logic [2:0] RB_INT_LO  = 3'd0;
  localparam logic [2:0] RB_INT_HI  = 3'd1;
  localparam logic [2:0] RB_DIST_LO = 3'd2;
  localparam logic [2:0] RB_DIST_HI = 3'd3;

  // controller -> datapath commands
  typedef struct packed {
    logic take_byte;
    logic rd_latch;
    logic rd_issue;
    logic clear_start;
    logic clear_step;
    logic commit_init;
    logic commit_step;
    logic load_frame;
    logic load_read;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last_byte;
    logic clear_last;
    logic frame_ok;
    logic commit_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/lsfd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 360
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lsfd_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfd_ctrl
// Sequencer: accepts items, walks the store clear sweep, frame evaluation,
// frame commit and read access, and hands results to the output register.
// ----------------------------------------------------------------------------
module lsfd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_opcode,
  input  lsfd_pkg::sts_t      sts,
  output lsfd_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_COMMIT,
    S_FRM_OUT,
    S_RD_ADDR,
    S_RD_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            lsfd_pkg::OP_RECV: begin
              cmd.take_byte = 1'b1;
              if (sts.last_byte) begin
                state_nxt = S_EVAL;
              end
            end
            lsfd_pkg::OP_READ: begin
              cmd.rd_latch = 1'b1;
              state_nxt    = S_RD_ADDR;
            end
            lsfd_pkg::OP_CLEAR: begin
              cmd.clear_start = 1'b1;
              state_nxt       = S_CLEAR;
            end
            default: ;  // unused opcode: dropped
          endcase
        end
      end
      S_EVAL: begin
        if (sts.frame_ok) begin
          cmd.commit_init = 1'b1;
          state_nxt       = S_COMMIT;
        end else begin
          state_nxt = S_FRM_OUT;
        end
      end
      S_COMMIT: begin
        cmd.commit_step = 1'b1;
        if (sts.commit_last) begin
          state_nxt = S_FRM_OUT;
        end
      end
      S_FRM_OUT: begin
        if (sts.out_free) begin
          cmd.load_frame = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (sts.out_free) begin
          cmd.load_read = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register; reset starts with a store clear sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/lsfd_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfd_dp
// Datapath: frame byte tracking and checksum, pending readings, distance
// filter, angle store RAM, configuration registers and output register.
// ----------------------------------------------------------------------------
module lsfd_dp #(
  parameter int NUM_ANGLES         = lsfd_pkg::NUM_ANGLES_DEF,
  parameter int READINGS_PER_FRAME = lsfd_pkg::READINGS_PER_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lsfd_pkg::cmd_t                cmd,
  output lsfd_pkg::sts_t                sts,
  input  logic [7:0]                    in_rx_byte,
  input  logic [lsfd_pkg::ANGLE_W-1:0]  in_angle,
  input  logic                          cfg_valid,
  input  logic [1:0]                    cfg_index,
  input  logic [lsfd_pkg::VAL_W-1:0]    cfg_wdata,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_frame_number,
  output logic [lsfd_pkg::VAL_W-1:0]    out_distance,
  output logic [lsfd_pkg::VAL_W-1:0]    out_intensity
);

  localparam int VW        = lsfd_pkg::VAL_W;
  localparam int AW        = $clog2(NUM_ANGLES);
  localparam int CW        = ((AW > lsfd_pkg::ANGLE_W) ? AW : lsfd_pkg::ANGLE_W) + 1;
  localparam int RIW       = (READINGS_PER_FRAME > 1) ? $clog2(READINGS_PER_FRAME) : 1;
  localparam int CheckPos  = lsfd_pkg::FIRST_READING
                             + lsfd_pkg::READING_BYTES * READINGS_PER_FRAME;
  localparam int FrameLen  = CheckPos + 2;
  localparam int PW        = $clog2(FrameLen);
  localparam int NumFrames = NUM_ANGLES / READINGS_PER_FRAME;

  // configuration
  logic [VW-1:0] dist_limit_r;
  logic [VW-1:0] min_int_r;
  logic          invert_r;

  // framing
  logic          in_frame_r;
  logic [PW-1:0] pos_r;
  logic [7:0]    sum_r;
  logic [7:0]    index_r;
  logic [7:0]    check_r;
  logic [RIW-1:0] rdg_r;
  logic [2:0]    rbyte_r;
  logic [VW-1:0] pend_dist_r [READINGS_PER_FRAME];
  logic [VW-1:0] pend_int_r  [READINGS_PER_FRAME];

  // store access
  logic [AW-1:0]  clr_r;
  logic [AW-1:0]  slot_r;
  logic [RIW-1:0] ci_r;
  logic [AW-1:0]  rd_slot_r;
  logic           rd_ok_r;

  // output register
  logic          out_valid_r;
  logic          out_kind_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_frame_number_r;
  logic [VW-1:0] out_distance_r;
  logic [VW-1:0] out_intensity_r;

  logic [7:0]    number;
  logic [1:0]    frame_status;
  logic [VW-1:0] cur_dist;
  logic [VW-1:0] cur_int;
  logic [VW-1:0] filt_dist;
  logic [CW-1:0] ang_ext;
  logic [CW-1:0] slot_full;
  logic          ang_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [2*VW-1:0] ram_wdata;
  logic [2*VW-1:0] ram_rdata;

  // frame verdict from the captured bytes
  assign number = index_r - lsfd_pkg::INDEX_BASE;

  always_comb begin
    if (check_r != (lsfd_pkg::CHECK_BASE - sum_r)) begin
      frame_status = lsfd_pkg::ST_BAD_SUM;
    end else if (32'(number) >= 32'(NumFrames)) begin
      frame_status = lsfd_pkg::ST_BAD_NUMBER;
    end else begin
      frame_status = lsfd_pkg::ST_STORED;
    end
  end

  // distance filter on the reading being committed
  assign cur_dist = pend_dist_r[ci_r];
  assign cur_int  = pend_int_r[ci_r];

  always_comb begin
    if (dist_limit_r == '0) begin
      filt_dist = cur_dist;
    end else if ((cur_int < min_int_r) || (cur_dist == '0) || (cur_dist > dist_limit_r)) begin
      filt_dist = dist_limit_r;
    end else begin
      filt_dist = cur_dist;
    end
  end

  // read slot, mirrored when inverted order is set
  assign ang_ext   = CW'(in_angle);
  assign ang_ok    = ang_ext < CW'(NUM_ANGLES);
  assign slot_full = (invert_r && (ang_ext != '0)) ? (CW'(NUM_ANGLES) - ang_ext) : ang_ext;

  // status to controller
  assign sts.last_byte   = in_frame_r && (pos_r == PW'(FrameLen - 1));
  assign sts.clear_last  = (clr_r == AW'(NUM_ANGLES - 1));
  assign sts.frame_ok    = (frame_status == lsfd_pkg::ST_STORED);
  assign sts.commit_last = (ci_r == RIW'(READINGS_PER_FRAME - 1));
  assign sts.out_free    = !out_valid_r || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_limit_r <= '0;
      min_int_r    <= '0;
      invert_r     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lsfd_pkg::CFG_DIST_LIMIT:    dist_limit_r <= cfg_wdata;
        lsfd_pkg::CFG_MIN_INTENSITY: min_int_r    <= cfg_wdata;
        lsfd_pkg::CFG_INVERT:        invert_r     <= cfg_wdata[0];
        default: ;  // no register here
      endcase
    end
  end

  // frame tracking control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
    end else if (cmd.clear_start) begin
      in_frame_r <= 1'b0;
    end else if (cmd.take_byte) begin
      if (!in_frame_r) begin
        if (in_rx_byte == lsfd_pkg::SYNC_BYTE) begin
          in_frame_r <= 1'b1;
        end
      end else if (pos_r == PW'(FrameLen - 1)) begin
        in_frame_r <= 1'b0;
      end
    end
  end

  // frame byte capture
  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      if (!in_frame_r) begin
        pos_r   <= PW'(1);
        sum_r   <= in_rx_byte;
        rdg_r   <= '0;
        rbyte_r <= '0;
      end else begin
        pos_r <= pos_r + PW'(1);
        if (pos_r < PW'(CheckPos)) begin
          sum_r <= sum_r + in_rx_byte;
        end
        if (pos_r == PW'(lsfd_pkg::INDEX_POS)) begin
          index_r <= in_rx_byte;
        end else if (pos_r == PW'(CheckPos)) begin
          check_r <= in_rx_byte;
        end else if (pos_r >= PW'(lsfd_pkg::FIRST_READING) && pos_r < PW'(CheckPos)) begin
          unique case (rbyte_r)
            lsfd_pkg::RB_INT_LO:  pend_int_r[rdg_r][7:0]   <= in_rx_byte;
            lsfd_pkg::RB_INT_HI:  pend_int_r[rdg_r][15:8]  <= in_rx_byte;
            lsfd_pkg::RB_DIST_LO: pend_dist_r[rdg_r][7:0]  <= in_rx_byte;
            lsfd_pkg::RB_DIST_HI: pend_dist_r[rdg_r][15:8] <= in_rx_byte;
            default: ;  // spare bytes of a reading
          endcase
          if (rbyte_r == 3'(lsfd_pkg::READING_BYTES - 1)) begin
            rbyte_r <= '0;
            rdg_r   <= rdg_r + RIW'(1);
          end else begin
            rbyte_r <= rbyte_r + 3'd1;
          end
        end
      end
    end
  end

  // clear sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clear_start) begin
      clr_r <= '0;
    end else if (cmd.clear_step) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // commit slot walk and read slot latch
  always_ff @(posedge clk) begin
    if (cmd.commit_init) begin
      slot_r <= AW'(number) * AW'(READINGS_PER_FRAME);
      ci_r   <= '0;
    end else if (cmd.commit_step) begin
      slot_r <= slot_r + AW'(1);
      ci_r   <= ci_r + RIW'(1);
    end
    if (cmd.rd_latch) begin
      rd_slot_r <= slot_full[AW-1:0];
      rd_ok_r   <= ang_ok;
    end
  end

  // store RAM: {intensity, distance}
  assign ram_we    = cmd.clear_step || cmd.commit_step;
  assign ram_waddr = cmd.clear_step ? clr_r : slot_r;
  assign ram_wdata = cmd.clear_step ? '0 : {cur_int, filt_dist};

  lsfd_ram #(
    .WIDTH (2 * VW),
    .DEPTH (NUM_ANGLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_issue),
    .raddr (rd_slot_r),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_frame || cmd.load_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      out_kind_r         <= lsfd_pkg::KIND_STATUS;
      out_status_r       <= frame_status;
      out_frame_number_r <= number;
      out_distance_r     <= '0;
      out_intensity_r    <= '0;
    end else if (cmd.load_read) begin
      out_kind_r         <= lsfd_pkg::KIND_READ;
      out_status_r       <= lsfd_pkg::ST_STORED;
      out_frame_number_r <= '0;
      out_distance_r     <= rd_ok_r ? ram_rdata[VW-1:0] : '0;
      out_intensity_r    <= rd_ok_r ? ram_rdata[2*VW-1:VW] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_status       = out_status_r;
  assign out_frame_number = out_frame_number_r;
  assign out_distance     = out_distance_r;
  assign out_intensity    = out_intensity_r;

endmodule

// ===== sv/lidar_scan_frame_decoder.sv =====
`timescale 1ns / 1ps
// A frame byte other than the last leaves the block ready for the next item. The last
//   byte of a frame runs the check, a store write per reading if stored, and the result.
// A read latches the angle, issues the registered read of the angle store RAM, then
//   loads the result. Clear zeroes one store entry per cycle.
// Reset: synchronous; the block first sweeps the store to zero, during which no item is
//   taken (config writes are always taken).
// ----------------------------------------------------------------------------
// lidar_scan_frame_decoder
// Decodes scan frames from a rotating range sensor byte stream into per-angle
// distance and intensity stores and serves reads of single angles.
// ----------------------------------------------------------------------------
module lidar_scan_frame_decoder #(
  parameter int NUM_ANGLES         = lsfd_pkg::NUM_ANGLES_DEF,
  parameter int READINGS_PER_FRAME = lsfd_pkg::READINGS_PER_FRAME_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [7:0]                    in_rx_byte,
  input  logic [lsfd_pkg::ANGLE_W-1:0]  in_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_kind,
  output logic [1:0]                    out_status,
  output logic [7:0]                    out_frame_number,
  output logic [lsfd_pkg::VAL_W-1:0]    out_distance,
  output logic [lsfd_pkg::VAL_W-1:0]    out_intensity,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [lsfd_pkg::VAL_W-1:0]    cfg_wdata
);

  lsfd_pkg::cmd_t cmd;
  lsfd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  lsfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsfd_dp #(
    .NUM_ANGLES         (NUM_ANGLES),
    .READINGS_PER_FRAME (READINGS_PER_FRAME)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_rx_byte       (in_rx_byte),
    .in_angle         (in_angle),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_status       (out_status),
    .out_frame_number (out_frame_number),
    .out_distance     (out_distance),
    .out_intensity    (out_intensity)
  );

endmodule
